>>> hdl/bf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 box filter
// Pixel and result types, register indexes, reset values and the reciprocal
// used to divide a window sum by nine.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int LINE_W = 2 * PIX_W;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W  = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every window sum up to 9 * 255.
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd480;

  // Channel 0 is blue, 1 is green, 2 is red.
  typedef logic [2:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    pixel_t           pix;
    logic             last;
  } result_t;

endpackage

>>> hdl/bf3_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_line_mem: line buffer memory
// One write port and one read port with registered read data. Each entry
// holds the pixel two rows up in the upper half and one row up in the lower.
// ----------------------------------------------------------------------------
module bf3_line_mem #(
  parameter int DEPTH = bf3_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bf3_pkg::LINE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [bf3_pkg::LINE_W-1:0] rd_data
);

  logic [bf3_pkg::LINE_W-1:0] mem_r [DEPTH];
  logic [bf3_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/box_filter_3x3_rgb.sv
`timescale 1ns / 1ps
// An accepted input word passes the stage 1 and stage 2 registers and then the result
// register, where its results are offered. One input word per cycle while results are taken;
// the line buffer takes one read and one write a cycle. A word that causes two results holds
// the result register until the first is taken and stalls the input meanwhile.
// Reset clears the position counters, the window columns and all valid flags and
// loads 640 x 480; the line buffers are not cleared, so words flow right after reset.
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb: 3x3 mean filter over a raster-order RGB frame
// Border pixels pass through; interior pixels are the truncated mean of their
// 3x3 neighborhood, emitted when the pixel below-right of them arrives.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb #(
  parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bf3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bf3_pkg::CH_W-1:0]      in_blue,
  input  logic [bf3_pkg::CH_W-1:0]      in_green,
  input  logic [bf3_pkg::CH_W-1:0]      in_red,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bf3_pkg::POS_W-1:0]     out_row,
  output logic [bf3_pkg::POS_W-1:0]     out_col,
  output logic [bf3_pkg::CH_W-1:0]      out_blue,
  output logic [bf3_pkg::CH_W-1:0]      out_green,
  output logic [bf3_pkg::CH_W-1:0]      out_red,
  output logic                          out_is_last
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = (WW > bf3_pkg::CFG_W) ? WW : bf3_pkg::CFG_W;
  localparam int HCMP = (HW > bf3_pkg::CFG_W) ? HW : bf3_pkg::CFG_W;
  localparam int PROD_W = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

  // Configuration registers.
  logic [bf3_pkg::CFG_W-1:0] frame_width_r;
  logic [bf3_pkg::CFG_W-1:0] frame_height_r;

  // Position of the next input word.
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;

  // Stage 1: word waits for its line buffer read.
  logic            p1_v_r;
  bf3_pkg::pixel_t p1_px_r;
  logic [RW-1:0]   p1_row_r;
  logic [CW-1:0]   p1_col_r;
  logic            p1_int_r, p1_brd_r;
  logic            p1_fwd_r;
  bf3_pkg::pixel_t p1_fwd_above_r, p1_fwd_two_r;

  // Stage 2: window sums.
  logic                              p2_v_r;
  logic [2:0][bf3_pkg::SUM_W-1:0]    p2_sum_r;
  bf3_pkg::pixel_t                   p2_px_r;
  logic [RW-1:0]                     p2_row_r;
  logic [CW-1:0]                     p2_col_r;
  logic                              p2_int_r, p2_brd_r;

  // Window columns x-1 (a) and x-2 (b); index 0 is two rows up.
  bf3_pkg::pixel_t win_a_r [3];
  bf3_pkg::pixel_t win_b_r [3];

  // Result register, up to two results.
  bf3_pkg::result_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic [WW-1:0] c_inc;
  logic [HW-1:0] r_inc;
  logic          cur_int, cur_brd;
  logic          en0, en1, en2, accept, wr_en, fwd_hit;

  logic [bf3_pkg::LINE_W-1:0] mem_q;
  bf3_pkg::pixel_t            above_eff, two_eff;
  bf3_pkg::pixel_t            col_px [3];
  logic [2:0][bf3_pkg::SUM_W-1:0] sum_s1;
  bf3_pkg::pixel_t            mean_px;
  bf3_pkg::result_t           int_res, brd_res;

  // --------------------------------------------------------------------------
  // Configuration and effective frame size
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bf3_pkg::RESET_FRAME_WIDTH;
      frame_height_r <= bf3_pkg::RESET_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        bf3_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        bf3_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (WCMP'(frame_width_r) == '0) begin
      w_eff = WW'(1);
    end else if (WCMP'(frame_width_r) > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (HCMP'(frame_height_r) == '0) begin
      h_eff = HW'(1);
    end else if (HCMP'(frame_height_r) > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: position of the arriving word
  // --------------------------------------------------------------------------
  // A counter left beyond a smaller frame size starts over at zero.
  assign c_cur = (WW'(col_cnt_r) >= w_eff) ? '0 : col_cnt_r;
  assign r_cur = (HW'(row_cnt_r) >= h_eff) ? '0 : row_cnt_r;
  assign c_inc = WW'(c_cur) + WW'(1);
  assign r_inc = HW'(r_cur) + HW'(1);

  assign cur_int = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
  assign cur_brd = (r_cur == '0) || (HW'(r_cur) == h_eff - HW'(1)) ||
                   (c_cur == '0) || (WW'(c_cur) == w_eff - WW'(1));

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (c_inc >= w_eff) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (r_inc >= h_eff) ? '0 : RW'(r_inc);
      end else begin
        col_cnt_nxt = CW'(c_inc);
        row_cnt_nxt = r_cur;
      end
    end
  end

  assign en2    = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign en1    = !p2_v_r || en2;
  assign en0    = !p1_v_r || en1;
  assign in_ready = en0;
  assign accept = in_valid && en0;
  assign wr_en  = p1_v_r && en1;

  // The word in stage 1 writes the entry that this word reads in the same
  // cycle; take its values directly instead of the stale read.
  assign fwd_hit = accept && wr_en && (p1_col_r == c_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (en0) begin
        p1_v_r <= in_valid;
      end
      if (en1) begin
        p2_v_r <= p1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_px_r        <= {in_red, in_green, in_blue};
      p1_row_r       <= r_cur;
      p1_col_r       <= c_cur;
      p1_int_r       <= cur_int;
      p1_brd_r       <= cur_brd;
      p1_fwd_r       <= fwd_hit;
      p1_fwd_above_r <= p1_px_r;
      p1_fwd_two_r   <= above_eff;
    end
  end

  bf3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (p1_col_r),
    .wr_data ({above_eff, p1_px_r}),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .rd_data (mem_q)
  );

  // --------------------------------------------------------------------------
  // Stage 1: new window column, window shift and channel sums
  // --------------------------------------------------------------------------
  assign above_eff = p1_fwd_r ? p1_fwd_above_r : mem_q[bf3_pkg::PIX_W-1:0];
  assign two_eff   = p1_fwd_r ? p1_fwd_two_r   : mem_q[bf3_pkg::LINE_W-1:bf3_pkg::PIX_W];

  always_comb begin
    col_px[0] = two_eff;
    col_px[1] = above_eff;
    col_px[2] = p1_px_r;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_s1[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        sum_s1[ch] = sum_s1[ch] + bf3_pkg::SUM_W'(col_px[k][ch])
                   + bf3_pkg::SUM_W'(win_a_r[k][ch]) + bf3_pkg::SUM_W'(win_b_r[k][ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_a_r[k] <= '0;
        win_b_r[k] <= '0;
      end
    end else if (wr_en) begin
      for (int k = 0; k < 3; k++) begin
        win_b_r[k] <= win_a_r[k];
        win_a_r[k] <= col_px[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      p2_sum_r <= sum_s1;
      p2_px_r  <= p1_px_r;
      p2_row_r <= p1_row_r;
      p2_col_r <= p1_col_r;
      p2_int_r <= p1_int_r;
      p2_brd_r <= p1_brd_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by nine and load the result register
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mean_px[ch] = bf3_pkg::CH_W'((PROD_W'(p2_sum_r[ch]) * PROD_W'(bf3_pkg::RECIP_NINE))
                                   >> bf3_pkg::RECIP_SHIFT);
    end
  end

  always_comb begin
    int_res.row  = bf3_pkg::POS_W'(RW'(p2_row_r - RW'(1)));
    int_res.col  = bf3_pkg::POS_W'(CW'(p2_col_r - CW'(1)));
    int_res.pix  = mean_px;
    int_res.last = !p2_brd_r;
    brd_res.row  = bf3_pkg::POS_W'(p2_row_r);
    brd_res.col  = bf3_pkg::POS_W'(p2_col_r);
    brd_res.pix  = p2_px_r;
    brd_res.last = 1'b1;
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (out_valid && out_ready) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
    if (p2_v_r && en2) begin
      cnt_nxt   = {1'b0, p2_int_r} + {1'b0, p2_brd_r};
      slot0_nxt = p2_int_r ? int_res : brd_res;
      slot1_nxt = brd_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid   = (cnt_r != 2'd0);
  assign out_row     = slot0_r.row;
  assign out_col     = slot0_r.col;
  assign out_blue    = slot0_r.pix[0];
  assign out_green   = slot0_r.pix[1];
  assign out_red     = slot0_r.pix[2];
  assign out_is_last = slot0_r.last;

endmodule

>>> hdl/bf3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_checker: port-level checks of the box filter
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module bf3_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bf3_pkg::POS_W-1:0]     out_row,
  input logic [bf3_pkg::POS_W-1:0]     out_col,
  input logic [bf3_pkg::CH_W-1:0]      out_blue,
  input logic [bf3_pkg::CH_W-1:0]      out_green,
  input logic [bf3_pkg::CH_W-1:0]      out_red,
  input logic                          out_is_last
);

  // No result word is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col) &&
      $stable(out_blue) && $stable(out_green) && $stable(out_red) &&
      $stable(out_is_last))
    else $error("stalled result word changed");

  // An interior result that is not last is followed at once by the border
  // pixel below and to the right of it.
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last |=> out_valid && out_is_last)
    else $error("second result of a word missing");

  a_pair_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last |=>
      out_row == bf3_pkg::POS_W'($past(out_row) + 1'b1) &&
      out_col == bf3_pkg::POS_W'($past(out_col) + 1'b1))
    else $error("border result does not follow its interior result position");

endmodule

bind box_filter_3x3_rgb bf3_checker u_bf3_checker (.*);
